// ===== design/tfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tfs_pkg - shared types and constants of the thruster fire sequencer
// Phase, mode and outcome codes, register map, reset values and the
// control struct passed between the step logic and the top level.
// ----------------------------------------------------------------------------
package tfs_pkg;

  localparam int unsigned TimeBitsDefault  = 16;
  localparam int unsigned CountBitsDefault = 16;

  typedef logic [2:0] phase_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] outcome_t;

  // sequence phases
  localparam phase_t PhIdle  = 3'd0;
  localparam phase_t PhCool  = 3'd1;
  localparam phase_t PhMain  = 3'd2;
  localparam phase_t PhDelay = 3'd3;
  localparam phase_t PhIgn   = 3'd4;
  localparam phase_t PhWait  = 3'd5;

  // item kinds
  localparam mode_t ModeTick  = 2'd0;
  localparam mode_t ModeStart = 2'd1;
  localparam mode_t ModeStop  = 2'd2;
  localparam mode_t ModeDone  = 2'd3;

  // outcomes
  localparam outcome_t OutNone      = 2'd0;
  localparam outcome_t OutSuccess   = 2'd1;
  localparam outcome_t OutFailCharge = 2'd2;
  localparam outcome_t OutFailDisch = 2'd3;

  // register map (word index)
  localparam logic [2:0] RegMainCharge = 3'd0;
  localparam logic [2:0] RegIgnDelay   = 3'd1;
  localparam logic [2:0] RegIgnCharge  = 3'd2;
  localparam logic [2:0] RegSenseWait  = 3'd3;
  localparam logic [2:0] RegCooldown   = 3'd4;

  localparam logic [15:0] MainChargeRst = 16'd36045;
  localparam logic [15:0] IgnDelayRst   = 16'd32;
  localparam logic [15:0] IgnChargeRst  = 16'd655;
  localparam logic [15:0] SenseWaitRst  = 16'd262;
  localparam logic [15:0] CooldownRst   = 16'd28461;

  typedef struct packed {
    logic [15:0] main_charge;
    logic [15:0] ign_delay;
    logic [15:0] ign_charge;
    logic [15:0] sense_wait;
    logic [15:0] cooldown;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] pulses_left;
    logic       pulse_en;
    logic       override;
    logic       drv_main;
    logic       drv_ign;
    outcome_t   outcome;
  } ctrl_t;

endpackage

// ===== design/tfs_cfg.sv =====
// ----------------------------------------------------------------------------
// tfs_cfg - APB register file of the thruster fire sequencer
// Five 16-bit timing registers, word aligned; pready is tied high.
// ----------------------------------------------------------------------------
module tfs_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel_i,
  input  logic           penable_i,
  input  logic           pwrite_i,
  input  logic [4:0]     paddr_i,
  input  logic [31:0]    pwdata_i,
  output logic [31:0]    prdata_o,
  output logic           pready_o,
  output tfs_pkg::cfg_t  cfg_o
);

  tfs_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx   = paddr_i[4:2];
  assign wr_en = psel_i & penable_i & pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        tfs_pkg::RegMainCharge: cfg_d.main_charge = pwdata_i[15:0];
        tfs_pkg::RegIgnDelay:   cfg_d.ign_delay   = pwdata_i[15:0];
        tfs_pkg::RegIgnCharge:  cfg_d.ign_charge  = pwdata_i[15:0];
        tfs_pkg::RegSenseWait:  cfg_d.sense_wait  = pwdata_i[15:0];
        tfs_pkg::RegCooldown:   cfg_d.cooldown    = pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.main_charge <= tfs_pkg::MainChargeRst;
      cfg_q.ign_delay   <= tfs_pkg::IgnDelayRst;
      cfg_q.ign_charge  <= tfs_pkg::IgnChargeRst;
      cfg_q.sense_wait  <= tfs_pkg::SenseWaitRst;
      cfg_q.cooldown    <= tfs_pkg::CooldownRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      tfs_pkg::RegMainCharge: prdata_o = {16'd0, cfg_q.main_charge};
      tfs_pkg::RegIgnDelay:   prdata_o = {16'd0, cfg_q.ign_delay};
      tfs_pkg::RegIgnCharge:  prdata_o = {16'd0, cfg_q.ign_charge};
      tfs_pkg::RegSenseWait:  prdata_o = {16'd0, cfg_q.sense_wait};
      tfs_pkg::RegCooldown:   prdata_o = {16'd0, cfg_q.cooldown};
      default:                prdata_o = 32'd0;
    endcase
  end

  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

endmodule

// ===== design/tfs_step.sv =====
// ----------------------------------------------------------------------------
// tfs_step - next-state logic of the thruster fire sequencer
// Applies one item (tick, start, stop, done edge) to the sequencer state.
// ----------------------------------------------------------------------------
module tfs_step #(
  parameter int unsigned TIME_BITS  = tfs_pkg::TimeBitsDefault,
  parameter int unsigned COUNT_BITS = tfs_pkg::CountBitsDefault
) (
  input  tfs_pkg::cfg_t          cfg_i,
  input  tfs_pkg::mode_t         mode_i,
  input  logic [7:0]             pulse_count_i,
  input  logic                   with_pulse_i,
  input  logic                   sense_override_i,
  input  logic                   sense_level_i,
  input  tfs_pkg::ctrl_t         ctrl_i,
  input  logic [TIME_BITS-1:0]   cnt_i,
  input  logic [COUNT_BITS-1:0]  fires_i,
  input  logic [COUNT_BITS-1:0]  faults_i,
  input  logic [15:0]            meas_i,
  output tfs_pkg::ctrl_t         ctrl_o,
  output logic [TIME_BITS-1:0]   cnt_o,
  output logic [COUNT_BITS-1:0]  fires_o,
  output logic [COUNT_BITS-1:0]  faults_o,
  output logic [15:0]            meas_o,
  output logic                   meas_valid_o
);

  function automatic logic [TIME_BITS-1:0] ld_time(input logic [15:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[TIME_BITS-1:0];
  endfunction

  logic                 running;
  logic                 halt;
  logic [TIME_BITS-1:0] dec;
  logic [31:0]          cnt_ext;

  assign running = (ctrl_i.phase >= tfs_pkg::PhCool) && (ctrl_i.phase <= tfs_pkg::PhWait);
  assign dec     = cnt_i - TIME_BITS'(1);
  assign cnt_ext = 32'(cnt_i);

  always_comb begin
    ctrl_o       = ctrl_i;
    cnt_o        = cnt_i;
    fires_o      = fires_i;
    faults_o     = faults_i;
    meas_o       = meas_i;
    meas_valid_o = 1'b0;
    halt         = 1'b0;

    unique case (mode_i)
      tfs_pkg::ModeTick: begin
        if (running) begin
          cnt_o = dec;
          if (dec == '0) begin
            unique case (ctrl_i.phase)
              tfs_pkg::PhCool: begin
                ctrl_o.drv_main = 1'b1;
                ctrl_o.phase    = tfs_pkg::PhMain;
                cnt_o           = ld_time(cfg_i.main_charge);
              end
              tfs_pkg::PhMain: begin
                ctrl_o.drv_main = 1'b0;
                ctrl_o.phase    = tfs_pkg::PhDelay;
                cnt_o           = ld_time(cfg_i.ign_delay);
              end
              tfs_pkg::PhDelay: begin
                ctrl_o.phase = tfs_pkg::PhIgn;
                cnt_o        = ld_time(cfg_i.ign_charge);
                if (ctrl_i.override || sense_level_i) begin
                  if (ctrl_i.pulse_en) ctrl_o.drv_ign = 1'b1;
                  else halt = 1'b1;
                end else begin
                  faults_o       = faults_i + COUNT_BITS'(1);
                  ctrl_o.outcome = tfs_pkg::OutFailCharge;
                  halt           = 1'b1;
                end
              end
              tfs_pkg::PhIgn: begin
                ctrl_o.drv_ign = 1'b0;
                ctrl_o.phase   = tfs_pkg::PhWait;
                cnt_o          = ld_time(cfg_i.sense_wait);
              end
              tfs_pkg::PhWait: begin
                if (!ctrl_i.override && sense_level_i) begin
                  faults_o       = faults_i + COUNT_BITS'(1);
                  ctrl_o.outcome = tfs_pkg::OutFailDisch;
                  halt           = 1'b1;
                end else begin
                  ctrl_o.outcome = tfs_pkg::OutSuccess;
                  fires_o        = fires_i + COUNT_BITS'(1);
                  if (ctrl_i.pulses_left != 8'd0) begin
                    ctrl_o.pulses_left = ctrl_i.pulses_left - 8'd1;
                    ctrl_o.phase       = tfs_pkg::PhCool;
                    cnt_o              = ld_time(cfg_i.cooldown);
                  end else begin
                    halt = 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      tfs_pkg::ModeStart: begin
        if (!running && pulse_count_i != 8'd0) begin
          ctrl_o.pulses_left = pulse_count_i - 8'd1;
          ctrl_o.pulse_en    = with_pulse_i;
          ctrl_o.override    = sense_override_i;
          ctrl_o.phase       = tfs_pkg::PhCool;
          cnt_o              = ld_time(cfg_i.cooldown);
        end
      end
      tfs_pkg::ModeStop: begin
        if (running) halt = 1'b1;
      end
      tfs_pkg::ModeDone: begin
        if (ctrl_i.phase == tfs_pkg::PhMain) begin
          meas_o       = cfg_i.main_charge - cnt_ext[15:0];
          meas_valid_o = 1'b1;
        end
      end
      default: ;
    endcase

    if (halt) begin
      ctrl_o.phase    = tfs_pkg::PhIdle;
      cnt_o           = '0;
      ctrl_o.drv_main = 1'b0;
      ctrl_o.drv_ign  = 1'b0;
      ctrl_o.pulse_en = 1'b1;
      ctrl_o.override = 1'b0;
    end
  end

endmodule

// ===== design/thruster_fire_sequencer.sv =====
// ----------------------------------------------------------------------------
// thruster_fire_sequencer - pulse thruster firing sequencer
// Runs cooldown, main charge, igniter delay, igniter charge and sense wait
// per pulse, checks the sense line, counts fires and faults and measures
// the main charge time on a done edge.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid_i/s_tready_o   tuser: mode; tdata: start args, sense
// m_*       out  m_tvalid_o/m_tready_i   tdata: drives, phase, counters, meas
// APB       in   psel/penable/pwrite     5 x 16-bit timing registers
//
// One item per cycle: the state update is a single decrement, compare and
// reload between the state registers, and each item's result is captured in
// a one-deep output register. An item is taken whenever that register is
// empty or is being drained in the same cycle, so a full register with
// m_tready_i low stalls the input side. Reset (rst_ni, async, low) clears
// all state to idle and loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
module thruster_fire_sequencer #(
  parameter int unsigned TIME_BITS  = tfs_pkg::TimeBitsDefault,
  parameter int unsigned COUNT_BITS = tfs_pkg::CountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // [7:0] pulse_count, [8] with_pulse, [9] sense_override, [10] sense_level,
  // [15:11] zero
  input  logic [15:0] s_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [0] main_charge_on, [1] igniter_charge_on, [2] active, [5:3] phase,
  // [21:6] fires_done, [37:22] faults_seen, [39:38] last_outcome,
  // [55:40] measured_charge, [56] measured_valid, [63:57] zero
  output logic [63:0] m_tdata_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  tfs_pkg::cfg_t cfg;

  tfs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  // sequencer state
  tfs_pkg::ctrl_t         ctrl_q, ctrl_d;
  logic [TIME_BITS-1:0]   cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]  fires_q, fires_d;
  logic [COUNT_BITS-1:0]  faults_q, faults_d;
  logic [15:0]            meas_q, meas_d;
  logic                   meas_valid;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;

  logic        accept;
  logic [31:0] fires_ext, faults_ext;

  assign s_tready_o = !out_valid_q || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;

  tfs_step #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cfg_i            (cfg),
    .mode_i           (s_tuser_i),
    .pulse_count_i    (s_tdata_i[7:0]),
    .with_pulse_i     (s_tdata_i[8]),
    .sense_override_i (s_tdata_i[9]),
    .sense_level_i    (s_tdata_i[10]),
    .ctrl_i           (ctrl_q),
    .cnt_i            (cnt_q),
    .fires_i          (fires_q),
    .faults_i         (faults_q),
    .meas_i           (meas_q),
    .ctrl_o           (ctrl_d),
    .cnt_o            (cnt_d),
    .fires_o          (fires_d),
    .faults_o         (faults_d),
    .meas_o           (meas_d),
    .meas_valid_o     (meas_valid)
  );

  // counters shown at 16 bits whatever their internal width
  assign fires_ext  = 32'(fires_d);
  assign faults_ext = 32'(faults_d);

  always_comb begin
    out_data_d = {7'd0,
                  meas_valid,
                  meas_d,
                  ctrl_d.outcome,
                  faults_ext[15:0],
                  fires_ext[15:0],
                  ctrl_d.phase,
                  (ctrl_d.phase != tfs_pkg::PhIdle),
                  ctrl_d.drv_ign,
                  ctrl_d.drv_main};
    out_valid_d = accept || (out_valid_q && !m_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.phase       <= tfs_pkg::PhIdle;
      ctrl_q.pulses_left <= 8'd0;
      ctrl_q.pulse_en    <= 1'b1;
      ctrl_q.override    <= 1'b0;
      ctrl_q.drv_main    <= 1'b0;
      ctrl_q.drv_ign     <= 1'b0;
      ctrl_q.outcome     <= tfs_pkg::OutNone;
      cnt_q              <= '0;
      fires_q            <= '0;
      faults_q           <= '0;
      meas_q             <= 16'd0;
      out_valid_q        <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        ctrl_q   <= ctrl_d;
        cnt_q    <= cnt_d;
        fires_q  <= fires_d;
        faults_q <= faults_d;
        meas_q   <= meas_d;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) out_data_q <= out_data_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_idle_drives_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.phase == tfs_pkg::PhIdle) |-> (!ctrl_q.drv_main && !ctrl_q.drv_ign))
    else $error("switch drive on while idle");

  a_drive_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.drv_main |-> (ctrl_q.phase == tfs_pkg::PhMain)) and
    (ctrl_q.drv_ign |-> (ctrl_q.phase == tfs_pkg::PhIgn)))
    else $error("switch drive outside its phase");

  a_counters_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(fires_q) && $stable(faults_q) && $stable(ctrl_q)))
    else $error("state changed without an accepted item");

endmodule
